// File: rtl/core/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants for the palette texel sampler: stream field
// layout, color mode codes and coordinate widths.
// ----------------------------------------------------------------------------
package cts_pkg;

    // Stream payload widths
    localparam int TDATA_W = 96;
    localparam int TUSER_W = 1;
    localparam int COLOR_W = 16;

    // Coordinate widths: texel x reaches 960 + 2047, rows reach 768 + 255
    localparam int COORD_X_W = 12;
    localparam int COORD_Y_W = 10;

    // Request kinds carried in tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_WRITE  = 1'b1;

    // Color modes from page bits 8:7 (modes 2 and 3 are both direct)
    localparam logic [1:0] MODE_PAL4   = 2'd0;
    localparam logic [1:0] MODE_PAL8   = 2'd1;
    localparam logic [1:0] MODE_DIRECT = 2'd2;
    localparam logic [1:0] MODE_DIRECT_ALT = 2'd3;

    // Input tdata layout, lowest field last in the declaration
    typedef struct packed {
        logic [4:0]         pad;
        logic [15:0]        write_data;
        logic [8:0]         write_y;
        logic [9:0]         write_x;
        logic signed [11:0] tex_v;
        logic signed [11:0] tex_u;
        logic [15:0]        palette_word;
        logic [15:0]        page_word;
    } req_fields_t;

endpackage

// File: rtl/core/clut_texel_sampler.sv
// ----------------------------------------------------------------------------
// clut_texel_sampler
// Video store of 16-bit words with word writes and palette texel sampling.
// ----------------------------------------------------------------------------
// One request is handled at a time, and s_axis_tready is low while it is in
// flight. A write registers the store address and then updates the store. A
// direct color sample registers the address, reads the store, registers the
// read word as the result and then loads it into the output register. A 4-bit
// or 8-bit palette sample passes through the address and read steps twice,
// since the palette index must come back from the store before the palette
// entry can be read. A sample whose texel address falls outside the store
// skips the read and loads 0 into the output register, as does a palette
// sample whose entry address alone misses, once its index word is read. The
// output register is loaded only once it is free; the sequencer then returns
// to idle and the next request can transfer. The sequence follows from the
// single store port with registered read data, and from one shared address
// unit (row times width plus column, then a register) used once per access.
// The output register lets the next request transfer while a result still
// waits on m_axis_tready. Writes produce no result transfer.
// ----------------------------------------------------------------------------
module clut_texel_sampler #(
    parameter int STORE_WIDTH  = 1024,
    parameter int STORE_HEIGHT = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // page_word[15:0], palette_word[31:16], tex_u[43:32], tex_v[55:44],
    // write_x[65:56], write_y[74:66], write_data[90:75], zero pad[95:91]
    input  logic [cts_pkg::TDATA_W-1:0]   s_axis_tdata,
    // req_type[0]
    input  logic [cts_pkg::TUSER_W-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // texel_color[15:0]
    output logic [cts_pkg::COLOR_W-1:0]   m_axis_tdata
);
    import cts_pkg::*;

    localparam int DEPTH  = STORE_WIDTH * STORE_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [COORD_X_W:0]   X_LIMIT = (COORD_X_W+1)'(STORE_WIDTH);
    localparam logic [COORD_Y_W+1:0] Y_LIMIT = (COORD_Y_W+2)'(STORE_HEIGHT);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADDR = 3'd1;
    localparam logic [2:0] S_MEM  = 3'd2;
    localparam logic [2:0] S_DATA = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic                 is_write_reg;
    logic                 pal_phase_reg;
    logic [1:0]           mode_reg;
    logic [1:0]           sel_reg;
    logic [COORD_X_W-1:0] coord_x_reg;
    logic [COORD_Y_W-1:0] coord_y_reg;
    logic [9:0]           pal_x_reg;
    logic [8:0]           pal_y_reg;
    logic [COLOR_W-1:0]   wdata_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [COLOR_W-1:0]   result_reg;
    logic [COLOR_W-1:0]   rd_data_reg;
    logic                 m_valid_reg;
    logic [COLOR_W-1:0]   m_data_reg;

    logic [COLOR_W-1:0]   store_mem [DEPTH];

    req_fields_t          req;
    logic                 in_xfer;
    logic                 in_range;
    logic                 out_free;

    // Request decode
    logic [1:0]           dec_mode;
    logic [9:0]           dec_base_x;
    logic [COORD_Y_W-1:0] dec_base_y;
    logic [10:0]          dec_u_pos;
    logic [7:0]           dec_u8;
    logic [7:0]           dec_v8;
    logic [10:0]          dec_u_off;

    // Palette index from the fetched word
    logic [7:0]           pal_idx;

    assign req     = req_fields_t'(s_axis_tdata);
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Decode page word and clamp coordinates
    always_comb begin
        dec_mode   = req.page_word[8:7];
        dec_base_x = {req.page_word[3:0], 6'd0};
        dec_base_y = {req.page_word[11], req.page_word[4], 8'd0};
        dec_u_pos  = req.tex_u[11] ? 11'd0 : req.tex_u[10:0];
        dec_u8     = (dec_u_pos[10:8] != 3'd0) ? 8'hFF : dec_u_pos[7:0];
        if (req.tex_v[11]) begin
            dec_v8 = 8'd0;
        end else if (req.tex_v[10:8] != 3'd0) begin
            dec_v8 = 8'hFF;
        end else begin
            dec_v8 = req.tex_v[7:0];
        end
        case (dec_mode)
            MODE_PAL4: dec_u_off = {5'd0, dec_u8[7:2]};
            MODE_PAL8: dec_u_off = {4'd0, dec_u8[7:1]};
            default:   dec_u_off = dec_u_pos;
        endcase
    end

    // Pick nibble or byte of the index word
    always_comb begin
        if (mode_reg == MODE_PAL4) begin
            case (sel_reg)
                2'd0:    pal_idx = {4'd0, rd_data_reg[3:0]};
                2'd1:    pal_idx = {4'd0, rd_data_reg[7:4]};
                2'd2:    pal_idx = {4'd0, rd_data_reg[11:8]};
                default: pal_idx = {4'd0, rd_data_reg[15:12]};
            endcase
        end else begin
            pal_idx = sel_reg[0] ? rd_data_reg[15:8] : rd_data_reg[7:0];
        end
    end

    // Range check for the shared address unit
    assign in_range = ({1'b0, coord_x_reg} < X_LIMIT)
                   && ({2'b00, coord_y_reg} < Y_LIMIT);

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                if (in_range) begin
                    state_next = S_MEM;
                end else if (is_write_reg) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_MEM: begin
                state_next = is_write_reg ? S_IDLE : S_DATA;
            end
            S_DATA: begin
                if (!pal_phase_reg && !mode_reg[1]) begin
                    state_next = S_ADDR;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    is_write_reg  <= (s_axis_tuser[0] == REQ_WRITE);
                    pal_phase_reg <= 1'b0;
                    mode_reg      <= dec_mode;
                    sel_reg       <= dec_u8[1:0];
                    pal_x_reg     <= {req.palette_word[5:0], 4'd0};
                    pal_y_reg     <= req.palette_word[14:6];
                    wdata_reg     <= req.write_data;
                    if (s_axis_tuser[0] == REQ_WRITE) begin
                        coord_x_reg <= COORD_X_W'(req.write_x);
                        coord_y_reg <= COORD_Y_W'(req.write_y);
                    end else begin
                        coord_x_reg <= COORD_X_W'(dec_base_x) + COORD_X_W'(dec_u_off);
                        coord_y_reg <= dec_base_y + COORD_Y_W'(dec_v8);
                    end
                end
            end
            S_ADDR: begin
                // Shared address unit: row times width plus column
                addr_reg   <= ADDR_W'(ADDR_W'(coord_y_reg) * ADDR_W'(STORE_WIDTH))
                            + ADDR_W'(coord_x_reg);
                result_reg <= '0;
            end
            S_DATA: begin
                if (!pal_phase_reg && !mode_reg[1]) begin
                    // Redirect to the palette entry
                    pal_phase_reg <= 1'b1;
                    coord_x_reg   <= COORD_X_W'(pal_x_reg) + COORD_X_W'(pal_idx);
                    coord_y_reg   <= COORD_Y_W'(pal_y_reg);
                end else begin
                    result_reg <= rd_data_reg;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    m_data_reg <= result_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Video store: up to one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (state_reg == S_MEM && is_write_reg) begin
            store_mem[addr_reg] <= wdata_reg;
        end
        rd_data_reg <= store_mem[addr_reg];
    end

endmodule

// File: tb/sv/clut_sample_checker.sv
// ----------------------------------------------------------------------------
// clut_sample_checker
// Watches both stream channels of the texel sampler, keeps a shadow of the
// video store, predicts the color of every sample request and compares each
// result transfer with the oldest predicted color.
// ----------------------------------------------------------------------------
module clut_sample_checker #(
    parameter int STORE_WIDTH  = 1024,
    parameter int STORE_HEIGHT = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    // page_word[15:0], palette_word[31:16], tex_u[43:32], tex_v[55:44],
    // write_x[65:56], write_y[74:66], write_data[90:75], zero pad[95:91]
    input  logic [cts_pkg::TDATA_W-1:0]   s_axis_tdata,
    // req_type[0]
    input  logic [cts_pkg::TUSER_W-1:0]   s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // texel_color[15:0]
    input  logic [cts_pkg::COLOR_W-1:0]   m_axis_tdata,
    output int unsigned                   fail_count,
    output int unsigned                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    // Shadow of the video store, keyed by row * width + column
    logic [15:0] vram_shadow [int unsigned];
    // Colors predicted for accepted samples, oldest first
    logic [15:0] expected_colors [$];
    int unsigned errors_seen = 0;

    // Read one shadow word; report a miss outside the store
    function automatic bit fetch_word(input int unsigned x, input int unsigned y,
                                      output logic [15:0] word);
        int unsigned addr;
        word = '0;
        if (x >= STORE_WIDTH || y >= STORE_HEIGHT)
            return 1'b0;
        addr = y * STORE_WIDTH + x;
        if (vram_shadow.exists(addr))
            word = vram_shadow[addr];
        return 1'b1;
    endfunction

    // Decode the page, clamp the coordinates and look up the texel color
    function automatic logic [15:0] predict_texel_color(input req_fields_t req);
        logic [1:0]  mode;
        int          u;
        int          v;
        int unsigned base_x;
        int unsigned base_y;
        int unsigned idx;
        logic [15:0] word;
        mode   = req.page_word[8:7];
        base_x = 64 * req.page_word[3:0];
        base_y = (req.page_word[4] ? 256 : 0) + (req.page_word[11] ? 512 : 0);
        u      = $signed(req.tex_u);
        v      = $signed(req.tex_v);
        if (u < 0) u = 0;
        if (v < 0) v = 0;
        if (v > 255) v = 255;

        // Direct modes return the stored word itself
        if (mode == MODE_DIRECT || mode == MODE_DIRECT_ALT) begin
            if (!fetch_word(base_x + u, base_y + v, word))
                return '0;
            return word;
        end

        // Palette modes: fetch the index word, pick the index, read the entry
        if (u > 255) u = 255;
        if (mode == MODE_PAL4) begin
            if (!fetch_word(base_x + u / 4, base_y + v, word))
                return '0;
            idx = (word >> (4 * (u % 4))) & 16'h000F;
        end else begin
            if (!fetch_word(base_x + u / 2, base_y + v, word))
                return '0;
            idx = (u % 2 != 0) ? word[15:8] : word[7:0];
        end
        if (!fetch_word(16 * req.palette_word[5:0] + idx, req.palette_word[14:6], word))
            return '0;
        return word;
    endfunction

    // Predict on input transfers, compare on result transfers
    always @(posedge aclk) begin : monitor
        req_fields_t req;
        logic [15:0] want;
        if (!aresetn) begin
            expected_colors.delete();
            pending    <= 0;
            fail_count <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                req = s_axis_tdata;
                if (s_axis_tuser[0] == REQ_WRITE) begin
                    if (req.write_x < STORE_WIDTH && req.write_y < STORE_HEIGHT)
                        vram_shadow[req.write_y * STORE_WIDTH + req.write_x] = req.write_data;
                end else begin
                    expected_colors.push_back(predict_texel_color(req));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_colors.size() == 0) begin
                    $error("texel_color: unexpected result transfer, expected none, got %h",
                           m_axis_tdata);
                    errors_seen++;
                end else begin
                    want = expected_colors.pop_front();
                    if (m_axis_tdata !== want) begin
                        $error("texel_color: expected %h, got %h", want, m_axis_tdata);
                        errors_seen++;
                    end
                end
            end
            pending    <= expected_colors.size();
            fail_count <= errors_seen;
        end
    end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives word writes and texel samples into the palette texel sampler with
// random idling on both channels, a long output stall and a full drain, and
// reports the verdict of the checker. Every word a sample reads is written
// beforehand, so no read ever touches an unwritten store word.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    localparam int STORE_W        = 1024;
    localparam int STORE_H        = 512;
    localparam int IDLE_PCT       = 31;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 450;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;
    logic [TUSER_W-1:0] s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [COLOR_W-1:0] m_axis_tdata;

    int unsigned fail_count;
    int unsigned pending;

    // Stimulus-side record of written words, used to keep reads on written data
    logic [15:0] written_words [int unsigned];

    logic        steady      = 1'b0;
    logic        rx_hold_req = 1'b0;
    logic        hold_seen   = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned items_sent  = 0;
    int unsigned n_writes    = 0;
    int unsigned n_samples   = 0;
    int unsigned n_outside   = 0;
    int unsigned mode_hits [4];

    clut_texel_sampler #(
        .STORE_WIDTH  (STORE_W),
        .STORE_HEIGHT (STORE_H)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    clut_sample_checker #(
        .STORE_WIDTH  (STORE_W),
        .STORE_HEIGHT (STORE_H)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver: random ready, a steady stretch and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (rx_hold_req != hold_seen) begin
            hold_seen     <= rx_hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request and hold it until the transfer
    task automatic send_item(input logic kind, input req_fields_t req);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= req;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        if (kind == REQ_WRITE)
            written_words[req.write_y * STORE_W + req.write_x] = req.write_data;
        items_sent++;
    endtask

    // Write one word; the sample fields carry random junk
    task automatic send_write(input int unsigned x, input int unsigned y,
                              input logic [15:0] data);
        req_fields_t req;
        req            = {$urandom, $urandom, $urandom};
        req.pad        = '0;
        req.write_x    = 10'(x);
        req.write_y    = 9'(y);
        req.write_data = data;
        n_writes++;
        send_item(REQ_WRITE, req);
    endtask

    // Sample one texel; first write any in-range word it will read
    task automatic send_sample(input logic [15:0] page, input logic [15:0] pal,
                               input logic [11:0] u_raw, input logic [11:0] v_raw);
        req_fields_t req;
        logic [1:0]  mode;
        int          u;
        int          v;
        int unsigned tx;
        int unsigned ty;
        int unsigned idx;
        logic [15:0] word;
        mode = page[8:7];
        u    = $signed(u_raw);
        v    = $signed(v_raw);
        if (u < 0) u = 0;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        if ((mode == MODE_PAL4 || mode == MODE_PAL8) && u > 255) u = 255;
        tx = 64 * page[3:0] + (mode == MODE_PAL4 ? u / 4 : mode == MODE_PAL8 ? u / 2 : u);
        ty = (page[4] ? 256 : 0) + (page[11] ? 512 : 0) + v;
        if (tx < STORE_W && ty < STORE_H) begin
            if (!written_words.exists(ty * STORE_W + tx))
                send_write(tx, ty, 16'($urandom));
            word = written_words[ty * STORE_W + tx];
            // Palette modes also read the entry the index points at
            if (mode == MODE_PAL4 || mode == MODE_PAL8) begin
                if (mode == MODE_PAL4)
                    idx = (word >> (4 * (u % 4))) & 16'h000F;
                else
                    idx = (u % 2 != 0) ? word[15:8] : word[7:0];
                tx = 16 * pal[5:0] + idx;
                ty = pal[14:6];
                if (tx < STORE_W && ty < STORE_H && !written_words.exists(ty * STORE_W + tx))
                    send_write(tx, ty, 16'($urandom));
            end
        end else begin
            n_outside++;
        end
        req              = {$urandom, $urandom, $urandom};
        req.pad          = '0;
        req.page_word    = page;
        req.palette_word = pal;
        req.tex_u        = u_raw;
        req.tex_v        = v_raw;
        mode_hits[mode]++;
        n_samples++;
        send_item(REQ_SAMPLE, req);
    endtask

    // Coordinate mix: half small, some around the cap, negatives, anywhere
    function automatic logic [11:0] pick_coord();
        case ($urandom_range(0, 5))
            0:       return 12'($urandom);
            1:       return 12'($urandom_range(240, 270));
            2:       return 12'hFFF - 12'($urandom_range(0, 15));
            default: return 12'($urandom_range(0, 63));
        endcase
    endfunction

    initial begin : stimulus
        logic [15:0] page;
        bit          hold_issued;
        bit          drained;
        hold_issued = 1'b0;
        drained     = 1'b0;
        foreach (mode_hits[i])
            mode_hits[i] = 0;

        // Hold reset, then release it
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: corners of the write fields
        send_write(0, 0, 16'h0000);
        send_write(STORE_W - 1, STORE_H - 1, 16'hFFFF);
        // 4-bit palette with both coordinates at the negative extreme
        send_sample(16'h0000, 16'h0000, 12'h800, 12'h800);
        // 8-bit palette with both coordinates at the positive extreme
        send_sample(16'h0080, 16'h0000, 12'h7FF, 12'h7FF);
        // Top nibble of a 4-bit index word
        send_write(1, 1, 16'hA5C3);
        send_sample(16'h0000, 16'h0041, 12'd7, 12'd1);
        // Both direct modes, and the last word of the store
        send_sample(16'h0100, 16'hFFFF, 12'd5, 12'd3);
        send_sample(16'h0185, 16'h0000, 12'd100, 12'd200);
        send_sample(16'h011F, 16'h0000, 12'd63, 12'd255);
        // Texel column beyond the store
        send_sample(16'h010F, 16'h0000, 12'h7FF, 12'd0);
        // Texel rows beyond the store
        send_sample(16'h0800, 16'h0000, 12'd0, 12'd0);
        send_sample(16'hFFFF, 16'hFFFF, 12'hFFF, 12'hFFF);
        // Palette entry beyond the last column
        send_write(2, 0, 16'hFFFF);
        send_sample(16'h0080, 16'h003F, 12'd5, 12'd0);
        // Palette at the last column group of the last row
        send_sample(16'h0000, 16'h7FFF, 12'd0, 12'd0);

        // Random traffic with one hold-off, a steady stretch and one drain
        while (items_sent < ITEM_TARGET) begin
            if (!hold_issued && items_sent >= 150) begin
                rx_hold_req <= ~rx_hold_req;
                hold_issued = 1'b1;
            end
            steady <= (items_sent >= 250 && items_sent < 330);
            if (!drained && items_sent >= 380) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0)
                    @(posedge aclk);
                drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 20) begin
                send_write($urandom_range(0, STORE_W - 1), $urandom_range(0, STORE_H - 1),
                           16'($urandom));
            end else begin
                page = 16'($urandom);
                if ($urandom_range(0, 3) != 0)
                    page[11] = 1'b0;
                send_sample(page, 16'($urandom), pick_coord(), pick_coord());
            end
        end

        // Drain the results, then keep the clock running for strays
        s_axis_tvalid <= 1'b0;
        steady        <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d word writes and %0d texel samples, %0d with the texel off the store",
                 n_writes, n_samples, n_outside);
        $display("Samples by mode: %0d 4-bit, %0d 8-bit, %0d direct, %0d direct alternate",
                 mode_hits[MODE_PAL4], mode_hits[MODE_PAL8], mode_hits[MODE_DIRECT],
                 mode_hits[MODE_DIRECT_ALT]);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
